/* hdl/bbrf_pkg.sv */
`default_nettype none

package bbrf_pkg;

  localparam int BBRF_FRAC_BITS = 16;
  localparam int CFG_IDX_W      = 1;
  localparam logic [7:0] MAX_EXP_RESET = 8'd100;
  localparam logic [5:0] MAX_BIS_RESET = 6'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIS = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_A,
    PH_WAIT_B,
    PH_EXP_A,
    PH_EXP_B,
    PH_MID
  } phase_t;

  typedef enum logic [1:0] {
    KIND_EVAL,
    KIND_ROOT,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_RANGE,
    ERR_BRACKET,
    ERR_BISECT
  } err_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic [30:0]        accuracy;
    logic signed [31:0] f_value;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] point;
    err_t               error_code;
  } result_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  // halve toward zero
  function automatic logic signed [31:0] half32(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = (v + {32'd0, v[32]}) >>> 1;
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/bbrf_move.sv */
`default_nettype none

module bbrf_move #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [31:0] from_pos,
  input  logic signed [31:0] other_pos,
  output logic signed [31:0] new_pos
);
  import bbrf_pkg::*;

  localparam int    FACT_W = FRAC_BITS + 2;
  localparam int    PROD_W = FRAC_BITS + 36;
  localparam longint FACTOR = ((longint'(8) << FRAC_BITS) + 2) / 5;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [PROD_W-1:0]  prod;
  logic [34:0]        m;
  logic signed [36:0] delta;
  logic signed [36:0] sum;
  logic               over;
  logic               under;

  always_comb begin
    diff  = {from_pos[31], from_pos} - {other_pos[31], other_pos};
    mag   = diff[32] ? 33'(-diff) : 33'(diff);
    prod  = PROD_W'(mag) * PROD_W'(FACT_W'(FACTOR))
          + (PROD_W'(1) << (FRAC_BITS - 1));
    m     = prod[FRAC_BITS +: 35];
    delta = diff[32] ? -$signed({2'b00, m}) : $signed({2'b00, m});
    sum   = {{5{from_pos[31]}}, from_pos} + delta;
    over  = !sum[36] && (|sum[35:31]);
    under = sum[36] && !(&sum[35:31]);
    if (over) begin
      new_pos = 32'sh7fff_ffff;
    end else if (under) begin
      new_pos = 32'sh8000_0000;
    end else begin
      new_pos = sum[31:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/bbrf_core.sv */
`default_nettype none

module bbrf_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  bbrf_pkg::item_t   item,
  input  logic [7:0]        max_exp,
  input  logic [5:0]        max_bis,
  output logic              res_vld,
  output bbrf_pkg::result_t res
);
  import bbrf_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic signed [31:0] end_a_r, end_a_nxt;
  logic signed [31:0] end_b_r, end_b_nxt;
  logic signed [31:0] val_a_r, val_a_nxt;
  logic signed [31:0] val_b_r, val_b_nxt;
  logic signed [31:0] dx_r, dx_nxt;
  logic signed [31:0] root_r, root_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic [7:0]         cnt_r, cnt_nxt;

  logic signed [31:0] f;
  logic signed [31:0] fa, fb;
  logic [7:0]         sc;
  logic               differ;
  logic [32:0]        abs_fa, abs_fb;
  logic               a_smaller;
  logic signed [31:0] mv_from, mv_other, moved;
  logic signed [31:0] root_b, dx_b;
  logic signed [32:0] diff_b;
  logic signed [31:0] xmid, root_m, dx_h;
  logic [32:0]        adx;
  logic               f_le0, stop;
  logic [7:0]         cnt_inc;

  bbrf_move #(.FRAC_BITS(FRAC_BITS)) u_move (
    .from_pos (mv_from),
    .other_pos(mv_other),
    .new_pos  (moved)
  );

  always_comb begin
    f  = item.f_value;
    fa = (phase_r == PH_WAIT_A || phase_r == PH_EXP_A) ? f : val_a_r;
    fb = (phase_r == PH_WAIT_B || phase_r == PH_EXP_B) ? f : val_b_r;
    sc = (phase_r == PH_WAIT_B) ? 8'd0 : cnt_r;
    differ    = (fa[31] && !fb[31] && fb != 0) || (fb[31] && !fa[31] && fa != 0);
    abs_fa    = fa[31] ? 33'(-{fa[31], fa}) : {1'b0, fa};
    abs_fb    = fb[31] ? 33'(-{fb[31], fb}) : {1'b0, fb};
    a_smaller = abs_fa < abs_fb;
    mv_from   = a_smaller ? end_a_r : end_b_r;
    mv_other  = a_smaller ? end_b_r : end_a_r;

    root_b = fa[31] ? end_a_r : end_b_r;
    diff_b = fa[31] ? ({end_b_r[31], end_b_r} - {end_a_r[31], end_a_r})
                    : ({end_a_r[31], end_a_r} - {end_b_r[31], end_b_r});
    dx_b   = half32(diff_b);

    xmid    = add_sat(root_r, dx_r);
    adx     = dx_r[31] ? 33'(-{dx_r[31], dx_r}) : {1'b0, dx_r};
    f_le0   = f[31] || (f == 0);
    root_m  = f_le0 ? xmid : root_r;
    stop    = (adx < {2'b00, acc_r}) || (f == 0);
    dx_h    = half32({dx_r[31], dx_r});
    cnt_inc = cnt_r + 8'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    end_a_nxt = end_a_r;
    end_b_nxt = end_b_r;
    val_a_nxt = val_a_r;
    val_b_nxt = val_b_r;
    dx_nxt    = dx_r;
    root_nxt  = root_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b1;
    res       = '{kind: KIND_EVAL, point: 32'sd0, error_code: ERR_NONE};

    if (!item.func) begin
      if (item.x_low == item.x_high) begin
        phase_nxt = PH_IDLE;
        res       = '{kind: KIND_ERROR, point: 32'sd0, error_code: ERR_RANGE};
      end else begin
        end_a_nxt = item.x_low;
        end_b_nxt = item.x_high;
        acc_nxt   = item.accuracy;
        val_a_nxt = 32'sd0;
        val_b_nxt = 32'sd0;
        dx_nxt    = 32'sd0;
        root_nxt  = 32'sd0;
        cnt_nxt   = 8'd0;
        phase_nxt = PH_WAIT_A;
        res.point = item.x_low;
      end
    end else begin
      case (phase_r)
        PH_WAIT_A: begin
          val_a_nxt = f;
          phase_nxt = PH_WAIT_B;
          res.point = end_b_r;
        end
        PH_WAIT_B, PH_EXP_A, PH_EXP_B: begin
          val_a_nxt = fa;
          val_b_nxt = fb;
          if (differ) begin
            root_nxt  = root_b;
            dx_nxt    = dx_b;
            cnt_nxt   = 8'd0;
            phase_nxt = PH_MID;
            res.point = add_sat(root_b, dx_b);
          end else if (sc >= max_exp) begin
            cnt_nxt   = sc;
            phase_nxt = PH_IDLE;
            res       = '{kind: KIND_ERROR, point: 32'sd0, error_code: ERR_BRACKET};
          end else begin
            cnt_nxt   = sc + 8'd1;
            res.point = moved;
            if (a_smaller) begin
              end_a_nxt = moved;
              phase_nxt = PH_EXP_A;
            end else begin
              end_b_nxt = moved;
              phase_nxt = PH_EXP_B;
            end
          end
        end
        PH_MID: begin
          root_nxt = root_m;
          cnt_nxt  = cnt_inc;
          if (stop) begin
            phase_nxt = PH_IDLE;
            res       = '{kind: KIND_ROOT, point: root_m, error_code: ERR_NONE};
          end else if (cnt_inc >= {2'b00, max_bis}) begin
            phase_nxt = PH_IDLE;
            res       = '{kind: KIND_ERROR, point: 32'sd0, error_code: ERR_BISECT};
          end else begin
            dx_nxt    = dx_h;
            res.point = add_sat(root_m, dx_h);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          res_vld   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      end_a_r <= '0;
      end_b_r <= '0;
      val_a_r <= '0;
      val_b_r <= '0;
      dx_r    <= '0;
      root_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      end_a_r <= end_a_nxt;
      end_b_r <= end_b_nxt;
      val_a_r <= val_a_nxt;
      val_b_r <= val_b_nxt;
      dx_r    <= dx_nxt;
      root_r  <= root_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/bracket_and_bisect_root_finder_unit.sv */
// Bracket-and-bisect root finder, signed fixed point with FRAC_BITS fraction bits.
// The function itself is evaluated outside. A start word (in_func = 0) brings
// two guesses and an accuracy; every later word (in_func = 1) returns f at the
// last point asked for. Each word gets one result word on the out_ channel:
// a point to evaluate, the root, or an error with its code. A value word that
// arrives with no search running gets no result.
// Both data channels use valid/stall: a word moves when valid is high and stall
// is low. The configuration channel (valid/ready, always ready) sets the
// expansion and bisection limits; the user must write it only while the block
// is idle, as the block itself does not enforce this. An accepted word is held
// in the input register, and the result register then loads from it through the
// single-pass step logic (sign test, one constant multiply for the 1.6x
// expansion, shift and saturating add). Throughput is one word per cycle while
// out_stall is low; the loop with the external evaluator sets the real pace.
// While out_stall holds a waiting result, the input register still takes one
// more word if it is empty, then in_stall rises until the result is taken.
// Synchronous reset clears the search state to idle, drops any word in flight
// and restores the limits to 100 expansions and 40 bisections.
`default_nettype none

module bracket_and_bisect_root_finder_unit #(
  parameter int FRAC_BITS = bbrf_pkg::BBRF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic signed [31:0]               in_x_low,
  input  logic signed [31:0]               in_x_high,
  input  logic [30:0]                      in_accuracy,
  input  logic signed [31:0]               in_f_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic signed [31:0]               out_point,
  output logic [1:0]                       out_error_code,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);
  import bbrf_pkg::*;

  logic       in_vld_r;
  item_t      in_item_r;
  logic       out_vld_r, out_vld_nxt;
  result_t    out_res_r;
  logic [7:0] max_exp_r;
  logic [5:0] max_bis_r;
  logic       adv;
  logic       step_en;
  logic       core_vld;
  result_t    core_res;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !adv;
  assign step_en   = in_vld_r && adv;
  assign cfg_ready = 1'b1;

  bbrf_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .item   (in_item_r),
    .max_exp(max_exp_r),
    .max_bis(max_bis_r),
    .res_vld(core_vld),
    .res    (core_res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = in_vld_r && core_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= '{func: in_func, x_low: in_x_low, x_high: in_x_high,
                     accuracy: in_accuracy, f_value: in_f_value};
    end
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_exp_r <= MAX_EXP_RESET;
      max_bis_r <= MAX_BIS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_EXP: max_exp_r <= cfg_data;
        CFG_MAX_BIS: max_bis_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_res_r.kind;
  assign out_point      = out_res_r.point;
  assign out_error_code = out_res_r.error_code;

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.kind == KIND_ERROR |->
      out_res_r.point == 32'sd0 && out_res_r.error_code != ERR_NONE)
    else $error("error result with nonzero point or no code");

  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.kind != KIND_ERROR |-> out_res_r.error_code == ERR_NONE)
    else $error("error code on a non-error result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
